// ===== hdl/apf_pkg.sv =====
// Package for the arithmetic progression finder: payload structs, opcodes,
// status codes and controller/datapath command types. No dependencies.
`default_nettype none
package apf_pkg;
	localparam int MAX_POINTS_DEF = 64;
	localparam int CNT_W = 7;

	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_SLICE   = 2'd0;
	localparam logic [1:0] ST_NOCHAIN = 2'd1;
	localparam logic [1:0] ST_NOSTART = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] slice_start;
		logic [31:0] slice_stop;
		logic [31:0] slice_step;
		logic [6:0]  point_count;
		logic        last;
	} out_item_t;

	// Datapath commands issued by the controller, one per cycle.
	typedef enum logic [3:0] {
		CMD_NONE     = 4'd0,
		CMD_LOAD     = 4'd1,  // write store (begin or append)
		CMD_FIND_INIT= 4'd2,  // idx <= 0, request read idx
		CMD_FIND_CMP = 4'd3,  // compare read data, advance idx
		CMD_T_INIT   = 4'd4,  // t <= first+1, read t
		CMD_T_STEP   = 4'd5,  // latch step from read t, cur <= t, m <= t+1
		CMD_CUR_RD   = 4'd6,  // read cur
		CMD_CUR_LAT  = 4'd7,  // latch cur value, read m
		CMD_M_CMP    = 4'd8,  // compare read m, advance m or hop
		CMD_EMIT     = 4'd9,  // emit pending slice if count>=3, t++
		CMD_FINAL    = 4'd10  // emit buffered or status result
	} cmd_t;

	typedef struct packed {
		logic start_hit;   // find compare matched
		logic find_end;    // idx reached total
		logic t_end;       // t reached total
		logic m_end;       // m reached total
		logic hop;         // read m matches cur+step
	} sts_t;
endpackage
`default_nettype wire

// ===== hdl/apf_datapath.sv =====
// Datapath of the arithmetic progression finder: point memory, index
// counters, step/chain registers and a one-deep result buffer. Uses apf_pkg.
`default_nettype none
module apf_datapath #(
	parameter int MAX_POINTS = apf_pkg::MAX_POINTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  apf_pkg::cmd_t         cmd,
	input  apf_pkg::in_item_t     item,
	output apf_pkg::sts_t         sts,
	output apf_pkg::out_item_t    result,
	output logic                  result_strobe
);
	import apf_pkg::*;
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic [31:0] mem [MAX_POINTS];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [CNT_W-1:0] total_q, idx_q, t_q, cur_q, m_q, first_q, count_q;
	logic [31:0] query_q, fval_q, step_q, curv_q;
	logic        pend_q;
	out_item_t   pend_item_q, res_q, pend_last;
	logic        res_v_q, any_q;
	logic [31:0] diff;

	assign diff = rd_q - curv_q;

	always_comb begin
		pend_last      = pend_item_q;
		pend_last.last = 1'b1;
	end

	// idle cycles keep the read port on t so the step point is ready
	always_comb begin
		rd_addr = t_q[AW-1:0];
		unique case (cmd)
			CMD_FIND_INIT: rd_addr = '0;
			CMD_FIND_CMP:  rd_addr = AW'(idx_q + CNT_W'(1));
			CMD_T_INIT:    rd_addr = AW'(first_q + CNT_W'(1));
			CMD_CUR_RD:    rd_addr = cur_q[AW-1:0];
			CMD_CUR_LAT:   rd_addr = m_q[AW-1:0];
			CMD_M_CMP:     rd_addr = AW'(m_q + CNT_W'(1));
			CMD_EMIT:      rd_addr = AW'(t_q + CNT_W'(1));
			default:       rd_addr = t_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			if (item.op == OP_BEGIN)
				mem[0] <= item.value;
			else if (total_q < CNT_W'(MAX_POINTS))
				mem[total_q[AW-1:0]] <= item.value;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		sts.start_hit = (rd_q == query_q) && (idx_q < total_q);
		sts.find_end  = (idx_q >= total_q);
		sts.t_end     = (t_q >= total_q);
		sts.m_end     = (m_q >= total_q);
		sts.hop       = (diff == step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pend_q  <= 1'b0;
			res_v_q <= 1'b0;
			any_q   <= 1'b0;
		end else begin
			res_v_q <= (cmd == CMD_FINAL) ||
				((cmd == CMD_EMIT) && (count_q >= CNT_W'(3)) && pend_q);
			unique case (cmd)
				CMD_LOAD: begin
					if (item.op == OP_BEGIN)
						total_q <= CNT_W'(1);
					else if (total_q < CNT_W'(MAX_POINTS))
						total_q <= total_q + CNT_W'(1);
				end
				CMD_FIND_INIT: begin
					pend_q <= 1'b0;
					any_q  <= 1'b0;
				end
				CMD_EMIT: begin
					if (count_q >= CNT_W'(3)) begin
						// flush previous slice, hold the new one for a last mark
						if (pend_q)
							res_q <= pend_item_q;
						pend_q <= 1'b1;
						any_q  <= 1'b1;
					end
				end
				CMD_FINAL: begin
					pend_q  <= 1'b0;
					if (pend_q) begin
						res_q <= pend_last;
					end else begin
						res_q.status      <= any_q ? ST_NOCHAIN :
							(sts.find_end ? ST_NOSTART : ST_NOCHAIN);
						res_q.slice_start <= '0;
						res_q.slice_stop  <= '0;
						res_q.slice_step  <= '0;
						res_q.point_count <= '0;
						res_q.last        <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_FIND_INIT: begin
				query_q <= item.value;
				idx_q   <= '0;
			end
			CMD_FIND_CMP: begin
				if (sts.start_hit) begin
					first_q <= idx_q;
					fval_q  <= rd_q;
				end else
					idx_q <= idx_q + CNT_W'(1);
			end
			CMD_T_INIT: t_q <= first_q + CNT_W'(1);
			CMD_T_STEP: begin
				step_q  <= rd_q - fval_q;
				cur_q   <= t_q;
				m_q     <= t_q + CNT_W'(1);
				count_q <= CNT_W'(2);
			end
			CMD_CUR_LAT: curv_q <= rd_q;
			CMD_M_CMP: begin
				if (sts.hop && !sts.m_end) begin
					cur_q   <= m_q;
					count_q <= count_q + CNT_W'(1);
					m_q     <= m_q + CNT_W'(1);
				end else
					m_q <= m_q + CNT_W'(1);
			end
			CMD_EMIT: begin
				t_q <= t_q + CNT_W'(1);
				if (count_q >= CNT_W'(3)) begin
					pend_item_q.status      <= ST_SLICE;
					pend_item_q.slice_start <= fval_q;
					pend_item_q.slice_stop  <= curv_q;
					pend_item_q.slice_step  <= step_q;
					pend_item_q.point_count <= count_q;
					pend_item_q.last        <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign result        = res_q;
	assign result_strobe = res_v_q;
endmodule
`default_nettype wire

// ===== hdl/apf_ctrl.sv =====
// Controller of the arithmetic progression finder: sequences loads and the
// query search over the datapath. Uses apf_pkg.
`default_nettype none
module apf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    op,
	input  apf_pkg::sts_t      sts,
	output apf_pkg::cmd_t      cmd,
	output logic               busy
);
	import apf_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_FIND  = 10'b0000000010,
		S_TINIT = 10'b0000000100,
		S_TWAIT = 10'b0000001000,
		S_TSTEP = 10'b0000010000,
		S_CURRD = 10'b0000100000,
		S_CURLT = 10'b0001000000,
		S_MCMP  = 10'b0010000000,
		S_EMIT  = 10'b0100000000,
		S_FINAL = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op) inside
						OP_BEGIN, OP_APPEND: cmd = CMD_LOAD;
						OP_QUERY: begin
							cmd     = CMD_FIND_INIT;
							state_d = S_FIND;
						end
						default: cmd = CMD_NONE;
					endcase
				end
			end
			S_FIND: begin
				if (sts.find_end)
					state_d = S_FINAL;
				else begin
					cmd = CMD_FIND_CMP;
					if (sts.start_hit)
						state_d = S_TINIT;
				end
			end
			S_TINIT: begin
				cmd     = CMD_T_INIT;
				state_d = S_TWAIT;
			end
			S_TWAIT: state_d = sts.t_end ? S_FINAL : S_TSTEP;
			S_TSTEP: begin
				cmd     = CMD_T_STEP;
				state_d = S_CURRD;
			end
			S_CURRD: begin
				cmd     = CMD_CUR_RD;
				state_d = S_CURLT;
			end
			S_CURLT: begin
				cmd     = CMD_CUR_LAT;
				state_d = S_MCMP;
			end
			S_MCMP: begin
				if (sts.m_end)
					state_d = S_EMIT;
				else begin
					cmd = CMD_M_CMP;
					// after a hop reload the new current point's value
					if (sts.hop)
						state_d = S_CURRD;
				end
			end
			S_EMIT: begin
				cmd     = CMD_EMIT;
				state_d = S_TWAIT;
			end
			S_FINAL: begin
				cmd     = CMD_FINAL;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== hdl/arithmetic_progression_finder_top.sv =====
// Top level of the arithmetic progression finder: joins controller and
// datapath. Uses apf_pkg, apf_ctrl, apf_datapath.
//
// Usage: drive in_item and raise start while busy is low; the item transfers
// at that edge. op 0 begins a new sequence, op 1 appends (ignored when full),
// op 2 queries from a start value; op 3 is dropped.
// Loads leave busy low. A query raises busy until its last result: the search
// walks the point memory through one read port, one stored point per cycle
// while finding the start, then for each candidate step point it reads the
// step, compares each later point in turn and reloads the current point's
// value after every hop.
// Results appear on result for one cycle each, marked by result_strobe; the
// final one carries last. The receiver cannot stall: each result transfers at
// the edge ending its strobe cycle.
// Reset clears the point count and the controller; the point memory is not
// cleared, and words not yet written never affect a result.
`default_nettype none
module arithmetic_progression_finder_top #(
	parameter int MAX_POINTS = apf_pkg::MAX_POINTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  apf_pkg::in_item_t     in_item,
	output apf_pkg::out_item_t    result,
	output logic                  result_strobe
);
	import apf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	apf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(in_item.op),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	apf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(in_item), .sts(sts),
		.result(result), .result_strobe(result_strobe)
	);

`ifndef SYNTHESIS
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FINAL) |=> (result_strobe && result.last))
		else $error("final transfer lacks last");
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.status != ST_SLICE) |-> !busy)
		else $error("status result while busy");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> !busy)
		else $error("load issued while busy");
`endif
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for arithmetic_progression_finder_top: loads point sequences,
// issues queries and checks every slice and status result against a local predictor.
// Depends on apf_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import apf_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;

	class slice_board;
		out_item_t pending[$];
		logic [31:0] pts[NPTS];
		int unsigned npts;
		int errors;

		function new();
			npts = 0;
			errors = 0;
		endfunction

		// note an accepted transfer and queue the slices it causes
		function void note_input(in_item_t it);
			out_item_t r;
			int first, t, cur, m, cnt, n;
			logic [31:0] stp;
			logic hop;
			bit found;
			found = 0;
			first = 0;
			n = 0;
			case (it.op)
				OP_BEGIN: begin
					pts[0] = it.value;
					npts = 1;
				end
				OP_APPEND: begin
					if (npts < NPTS) begin
						pts[npts] = it.value;
						npts++;
					end
				end
				OP_QUERY: begin
					for (int i = 0; i < npts; i++)
						if (!found && pts[i] == it.value) begin
							found = 1;
							first = i;
						end
					r = '0;
					if (!found) begin
						r.status = ST_NOSTART;
						r.last = 1'b1;
						pending.push_back(r);
					end else begin
						for (t = first + 1; t < npts; t++) begin
							stp = pts[t] - pts[first];
							cur = t;
							cnt = 2;
							do begin
								hop = 0;
								for (m = cur + 1; m < npts && !hop; m++)
									if (pts[m] - pts[cur] == stp) begin
										hop = 1;
										cur = m;
										cnt++;
									end
							end while (hop);
							if (cnt >= 3) begin
								r = '0;
								r.status = ST_SLICE;
								r.slice_start = pts[first];
								r.slice_stop = pts[cur];
								r.slice_step = stp;
								r.point_count = cnt[6:0];
								pending.push_back(r);
								n++;
							end
						end
						if (n == 0) begin
							r = '0;
							r.status = ST_NOCHAIN;
							r.last = 1'b1;
							pending.push_back(r);
						end else begin
							r = pending.pop_back();
							r.last = 1'b1;
							pending.push_back(r);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected st=%0d start=%h stop=%h step=%h",
						" cnt=%0d last=%0d got st=%0d start=%h stop=%h step=%h",
						" cnt=%0d last=%0d"},
						want.status, want.slice_start, want.slice_stop, want.slice_step,
						want.point_count, want.last, got.status, got.slice_start,
						got.slice_stop, got.slice_step, got.point_count, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	out_item_t result;
	logic result_strobe;
	slice_board board = new();
	logic [31:0] seq_vals[$];
	int unsigned sent_items = 0;

	arithmetic_progression_finder_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .result(result), .result_strobe(result_strobe)
	);

	always #10 clk = ~clk;

	always @(posedge clk)
		if (arst_n && result_strobe)
			board.check_result(result);

	always @(posedge clk)
		if (start && !busy && arst_n) sent_items <= sent_items + 1;

	function automatic int unsigned i_count();
		return sent_items;
	endfunction

	// transfer one item, after an optional random idle gap; start stays high afterwards
	task automatic send(logic [1:0] op, logic [31:0] val, bit gap = 1);
		int unsigned w;
		w = gap ? $urandom_range(0, 10) : 0;
		if (w != 0) begin
			start <= 1'b0;
			in_item <= '{op: 2'($urandom), value: $urandom};
			repeat (w) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= '{op: op, value: val};
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_input('{op: op, value: val});
	endtask

	task automatic drain();
		start <= 1'b0;
		in_item <= '{op: 2'($urandom), value: $urandom};
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// load an arithmetic run with noise and query from a chosen point
	task automatic shaped_set(int unsigned len);
		logic [31:0] base, stp;
		seq_vals.delete();
		base = $urandom;
		stp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0)
				seq_vals.push_back(base + $urandom_range(0, 7) * stp + $urandom_range(0, 1));
			else
				seq_vals.push_back(base + i * stp);
		end
		send(OP_BEGIN, seq_vals[0]);
		for (int i = 1; i < len; i++)
			send(OP_APPEND, seq_vals[i]);
		send(OP_QUERY, seq_vals[$urandom_range(0, len - 1)]);
		if ($urandom_range(0, 2) == 0)
			send(OP_QUERY, $urandom);
	endtask

	initial begin
		int unsigned len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// empty store, unused opcode
		send(OP_QUERY, 32'h0);
		send(2'd3, 32'hFFFF_FFFF);
		// tiny sequence, no chain
		send(OP_BEGIN, 32'hFFFF_FFFF);
		send(OP_APPEND, 32'h0);
		send(OP_QUERY, 32'hFFFF_FFFF);
		// wrapping chain and missing start
		send(OP_APPEND, 32'h1);
		send(OP_APPEND, 32'h2);
		send(OP_QUERY, 32'hFFFF_FFFF);
		send(OP_QUERY, 32'h1234_5678);
		// all equal values (step zero)
		send(OP_BEGIN, 32'h0);
		repeat (4) send(OP_APPEND, 32'h0);
		send(OP_QUERY, 32'h0);
		drain();
		// full store, then ignored appends
		send(OP_BEGIN, 32'h0, 0);
		for (int i = 1; i < NPTS; i++) send(OP_APPEND, 32'(i * 3), 0);
		send(OP_APPEND, 32'hDEAD_BEEF);
		send(OP_APPEND, 32'h5555_AAAA);
		send(OP_QUERY, 32'h0);
		send(OP_QUERY, 32'hDEAD_BEEF);
		drain();
		while (i_count() < 290) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, NPTS + 2)
				: $urandom_range(1, 10);
			shaped_set(len);
			if ($urandom_range(0, 15) == 0) drain();
		end
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("** arithmetic_progression_finder_top: PASSED **");
		else
			$display("** arithmetic_progression_finder_top: FAILED **");
		$finish;
	end

	initial begin
		#(60_000_000);
		$display("** arithmetic_progression_finder_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/apf_pkg.sv
hdl/apf_datapath.sv
hdl/apf_ctrl.sv
hdl/arithmetic_progression_finder_top.sv
verif/testbench.sv
